// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the tokenizer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define TOK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TOK_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define TOK_ASSERT(lbl, clk, rstn, prop, msg)
`define TOK_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// File: design/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// types, constants and helper functions shared by the tokenizer modules
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int POS_WIDTH  = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [POS_WIDTH-1:0] pos_t;
    typedef logic [5:0]           kind_t;

    // token kinds that the control logic refers to by name
    localparam kind_t K_EOF = 6'd0;
    localparam kind_t K_EQ = 6'd5;
    localparam kind_t K_GT = 6'd6;
    localparam kind_t K_LT = 6'd7;
    localparam kind_t K_MUL = 6'd10;
    localparam kind_t K_EQEQ = 6'd27;
    localparam kind_t K_MULEQ = 6'd46;
    localparam kind_t K_EQEQEQ = 6'd49;
    localparam kind_t K_IDENT = 6'd58;
    localparam kind_t K_INT = 6'd59;
    localparam kind_t K_DEC = 6'd60;
    localparam kind_t K_STR = 6'd61;

    typedef enum logic [4:0] {
        M_IDLE, M_EQ1, M_EQ2, M_CMP1, M_CMP2S, M_CMP2E, M_DBL1, M_DBL2, M_OPT,
        M_XMUL, M_IDENT, M_INT, M_FRAC, M_STR, M_WS, M_HASH1, M_LINE, M_BLOCK
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start;
        logic [31:0] length;
        logic        err;
        logic        last;
    } tok_result_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // offset difference, saturated to 32 bits
    function automatic logic [31:0] tok_len(input pos_t endp, input pos_t beg);
        pos_t d;
        d = endp - beg;
        if (64'(d) > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return 32'(d);
    endfunction

    // doubling operators: | & ^ /
    function automatic logic [7:0] dbl_char(input kind_t k);
        unique case (k)
            6'd16:   return "&";
            6'd17:   return "^";
            6'd11:   return "/";
            default: return "|";
        endcase
    endfunction

    function automatic kind_t dbl_eq(input kind_t k);
        unique case (k)
            6'd16:   return 6'd38;
            6'd17:   return 6'd39;
            6'd11:   return 6'd47;
            default: return 6'd37;
        endcase
    endfunction

    function automatic kind_t dbl_two(input kind_t k);
        unique case (k)
            6'd16:   return 6'd31;
            6'd17:   return 6'd32;
            6'd11:   return 6'd33;
            default: return 6'd30;
        endcase
    endfunction

    function automatic kind_t dbl_two_eq(input kind_t k);
        unique case (k)
            6'd16:   return 6'd51;
            6'd17:   return 6'd52;
            6'd11:   return 6'd53;
            default: return 6'd50;
        endcase
    endfunction

    function automatic kind_t dbl_one(input kind_t k);
        unique case (k)
            6'd16:   return 6'd16;
            6'd17:   return 6'd17;
            6'd11:   return 6'd11;
            default: return 6'd15;
        endcase
    endfunction

    // single operators that take an optional '='
    function automatic kind_t opt_eq(input kind_t k);
        unique case (k)
            6'd8:    return 6'd44;
            6'd9:    return 6'd45;
            6'd12:   return 6'd34;
            6'd13:   return 6'd43;
            6'd14:   return 6'd48;
            6'd19:   return 6'd41;
            6'd20:   return 6'd42;
            default: return 6'd40;
        endcase
    endfunction

    function automatic kind_t opt_one(input kind_t k);
        unique case (k)
            6'd8, 6'd9, 6'd12, 6'd13, 6'd14, 6'd19, 6'd20: return k;
            default: return 6'd18;
        endcase
    endfunction

endpackage

// File: design/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// scanner state and the per-byte transition producing up to two results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stt_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [7:0]          in_byte,
    output stt_pkg::tok_result_t res0,
    output stt_pkg::tok_result_t res1,
    output logic [1:0]          res_cnt
);
    import stt_pkg::*;

    mode_t mode_reg, mode_next;
    pos_t  pos_reg, pos_next;
    pos_t  tb_reg, tb_next;
    kind_t pk_reg, pk_next;
    logic  dq_reg, dq_next;
    logic  esc_reg, esc_next;
    logic  hr_reg, hr_next;
    logic  halted_reg, halted_next;

    logic        again, fin;
    kind_t       fin_kind;
    pos_t        fin_end, nxt;
    logic        bt_emit;
    tok_result_t fin_res, bt_res, err_res;
    logic        str_err;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tb_reg     <= '0;
            pk_reg     <= '0;
            dq_reg     <= 1'b0;
            esc_reg    <= 1'b0;
            hr_reg     <= 1'b0;
            halted_reg <= 1'b0;
        end else if (in_fire && !halted_reg) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tb_reg     <= tb_next;
            pk_reg     <= pk_next;
            dq_reg     <= dq_next;
            esc_reg    <= esc_next;
            hr_reg     <= hr_next;
            halted_reg <= halted_next;
        end
    end

    // transition for one byte
    always_comb begin
        logic [7:0] b;
        b           = in_byte;
        nxt         = pos_reg + pos_t'(1);
        pos_next    = nxt;
        mode_next   = mode_reg;
        tb_next     = tb_reg;
        pk_next     = pk_reg;
        dq_next     = dq_reg;
        esc_next    = esc_reg;
        hr_next     = hr_reg;
        halted_next = halted_reg;
        again       = 1'b0;
        fin         = 1'b0;
        fin_kind    = K_EOF;
        fin_end     = pos_reg;
        str_err     = 1'b0;

        unique case (mode_reg)
            M_EQ1: begin
                if (b == "=") mode_next = M_EQ2;
                else begin fin = 1'b1; fin_kind = K_EQ; again = 1'b1; end
            end
            M_EQ2: begin
                fin = 1'b1;
                if (b == "=") begin fin_kind = K_EQEQEQ; fin_end = nxt; end
                else begin fin_kind = K_EQEQ; again = 1'b1; end
            end
            M_CMP1: begin
                if (b == ((pk_reg == K_GT) ? ">" : "<")) mode_next = M_CMP2S;
                else if (b == "=") mode_next = M_CMP2E;
                else begin fin = 1'b1; fin_kind = pk_reg; again = 1'b1; end
            end
            M_CMP2S, M_CMP2E: begin
                fin = 1'b1;
                if (b == "=") begin
                    fin_end = nxt;
                    if (mode_reg == M_CMP2S) fin_kind = (pk_reg == K_GT) ? 6'd54 : 6'd55;
                    else fin_kind = (pk_reg == K_GT) ? 6'd56 : 6'd57;
                end else begin
                    again = 1'b1;
                    if (mode_reg == M_CMP2S) fin_kind = (pk_reg == K_GT) ? 6'd35 : 6'd36;
                    else fin_kind = (pk_reg == K_GT) ? 6'd28 : 6'd29;
                end
            end
            M_DBL1: begin
                if (b == dbl_char(pk_reg)) mode_next = M_DBL2;
                else if (b == "=") begin
                    fin = 1'b1; fin_kind = dbl_eq(pk_reg); fin_end = nxt;
                end else begin
                    fin = 1'b1; fin_kind = dbl_one(pk_reg); again = 1'b1;
                end
            end
            M_DBL2: begin
                fin = 1'b1;
                if (b == "=") begin fin_kind = dbl_two_eq(pk_reg); fin_end = nxt; end
                else begin fin_kind = dbl_two(pk_reg); again = 1'b1; end
            end
            M_OPT: begin
                fin = 1'b1;
                if (b == "=") begin fin_kind = opt_eq(pk_reg); fin_end = nxt; end
                else begin fin_kind = opt_one(pk_reg); again = 1'b1; end
            end
            M_XMUL: begin
                if (b == "=") begin
                    fin = 1'b1; fin_kind = K_MULEQ; fin_end = nxt;
                end else if (is_alpha(b) || b == "_") begin
                    mode_next = M_IDENT; pk_next = K_IDENT;
                end else begin
                    fin = 1'b1; fin_kind = K_MUL; again = 1'b1;
                end
            end
            M_IDENT: begin
                if (!(is_alpha(b) || is_digit(b) || b == "_")) begin
                    fin = 1'b1; fin_kind = K_IDENT; again = 1'b1;
                end
            end
            M_INT: begin
                if (b == ".") begin
                    mode_next = M_FRAC; pk_next = K_DEC;
                end else if (!is_digit(b)) begin
                    fin = 1'b1; fin_kind = K_INT; again = 1'b1;
                end
            end
            M_FRAC: begin
                if (!is_digit(b)) begin fin = 1'b1; fin_kind = K_DEC; again = 1'b1; end
            end
            M_STR: begin
                if (b == 8'd0) begin
                    str_err = 1'b1; halted_next = 1'b1;
                end else if (esc_reg) esc_next = 1'b0;
                else if (b == "\\") esc_next = 1'b1;
                else if (b == (dq_reg ? "\"" : "'")) begin
                    fin = 1'b1; fin_kind = K_STR; fin_end = nxt;
                end
            end
            M_WS: begin
                if (!is_space(b)) begin mode_next = M_IDLE; again = 1'b1; end
            end
            M_HASH1: begin
                if (b == "#") begin mode_next = M_BLOCK; hr_next = 1'b0; end
                else if (b == "\n" || b == 8'd0) begin mode_next = M_IDLE; again = 1'b1; end
                else mode_next = M_LINE;
            end
            M_LINE: begin
                if (b == "\n" || b == 8'd0) begin mode_next = M_IDLE; again = 1'b1; end
            end
            M_BLOCK: begin
                if (b == 8'd0) begin mode_next = M_IDLE; again = 1'b1; end
                else if (b == "#") begin
                    if (hr_reg) begin hr_next = 1'b0; mode_next = M_IDLE; end
                    else hr_next = 1'b1;
                end else hr_next = 1'b0;
            end
            default: again = 1'b1;
        endcase

        if (fin) mode_next = M_IDLE;

        // start of a new token at this byte
        bt_emit = 1'b0;
        bt_res  = '0;
        bt_res.start = 32'(pos_reg);
        if (again) begin
            tb_next   = pos_reg;
            mode_next = M_IDLE;
            priority case (b)
                8'd0: begin
                    bt_emit = 1'b1; bt_res.kind = K_EOF; halted_next = 1'b1;
                end
                ":": begin bt_emit = 1'b1; bt_res.kind = 6'd1; bt_res.length = 32'd1; end
                ".": begin bt_emit = 1'b1; bt_res.kind = 6'd2; bt_res.length = 32'd1; end
                ",": begin bt_emit = 1'b1; bt_res.kind = 6'd3; bt_res.length = 32'd1; end
                ";": begin bt_emit = 1'b1; bt_res.kind = 6'd4; bt_res.length = 32'd1; end
                "(": begin bt_emit = 1'b1; bt_res.kind = 6'd21; bt_res.length = 32'd1; end
                ")": begin bt_emit = 1'b1; bt_res.kind = 6'd22; bt_res.length = 32'd1; end
                "[": begin bt_emit = 1'b1; bt_res.kind = 6'd23; bt_res.length = 32'd1; end
                "]": begin bt_emit = 1'b1; bt_res.kind = 6'd24; bt_res.length = 32'd1; end
                "{": begin bt_emit = 1'b1; bt_res.kind = 6'd25; bt_res.length = 32'd1; end
                "}": begin bt_emit = 1'b1; bt_res.kind = 6'd26; bt_res.length = 32'd1; end
                "|": begin mode_next = M_DBL1; pk_next = 6'd15; end
                "&": begin mode_next = M_DBL1; pk_next = 6'd16; end
                "^": begin mode_next = M_DBL1; pk_next = 6'd17; end
                "/": begin mode_next = M_DBL1; pk_next = 6'd11; end
                "~": begin mode_next = M_OPT; pk_next = 6'd18; end
                "-": begin mode_next = M_OPT; pk_next = 6'd8; end
                "+": begin mode_next = M_OPT; pk_next = 6'd9; end
                "%": begin mode_next = M_OPT; pk_next = 6'd12; end
                "!": begin mode_next = M_OPT; pk_next = 6'd13; end
                "?": begin mode_next = M_OPT; pk_next = 6'd14; end
                "@": begin mode_next = M_OPT; pk_next = 6'd19; end
                "*": begin mode_next = M_OPT; pk_next = 6'd20; end
                ">": begin mode_next = M_CMP1; pk_next = K_GT; end
                "<": begin mode_next = M_CMP1; pk_next = K_LT; end
                "\"", "'": begin
                    mode_next = M_STR; dq_next = (b == "\""); esc_next = 1'b0;
                end
                "=": mode_next = M_EQ1;
                " ", "\t", "\n": mode_next = M_WS;
                "#": mode_next = M_HASH1;
                default: begin
                    if (is_digit(b)) begin
                        mode_next = M_INT; pk_next = K_INT;
                    end else if (b == "x") mode_next = M_XMUL;
                    else if (is_alpha(b) || b == "_") begin
                        mode_next = M_IDENT; pk_next = K_IDENT;
                    end else begin
                        bt_emit = 1'b1; bt_res.kind = K_EOF; bt_res.length = 32'd1;
                        bt_res.err = 1'b1; halted_next = 1'b1;
                    end
                end
            endcase
        end

        // results of a finished token and of an unterminated string
        fin_res        = '0;
        fin_res.kind   = fin_kind;
        fin_res.start  = 32'(tb_reg);
        fin_res.length = tok_len(fin_end, tb_reg);
        err_res        = '0;
        err_res.start  = 32'(tb_reg);
        err_res.length = tok_len(pos_reg, tb_reg);
        err_res.err    = 1'b1;

        // pack into result slots, last flag on the final one
        res0    = '0;
        res1    = '0;
        res_cnt = 2'd0;
        if (!halted_reg) begin
            if (str_err) begin
                res0 = err_res; res0.last = 1'b1; res_cnt = 2'd1;
            end else if (fin && bt_emit) begin
                res0 = fin_res; res1 = bt_res; res1.last = 1'b1; res_cnt = 2'd2;
            end else if (fin) begin
                res0 = fin_res; res0.last = 1'b1; res_cnt = 2'd1;
            end else if (bt_emit) begin
                res0 = bt_res; res0.last = 1'b1; res_cnt = 2'd1;
            end
        end
    end

    // checks
    `TOK_ASSERT(a_halt_sticks, aclk, aresetn, halted_reg |=> halted_reg, "halt released")
    `TOK_ASSERT(a_halt_frozen, aclk, aresetn, halted_reg |=> $stable(pos_reg), "pos moved while halted")
    `TOK_NEVER(a_pair_first_ok, aclk, aresetn, res_cnt == 2'd2 && (res0.err || res0.last), "bad pair")
endmodule

// File: design/stt_fifo.sv
// ----------------------------------------------------------------------------
// stt_fifo
// small result queue taking up to two beats per cycle and giving one
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stt_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           push_cnt,
    input  stt_pkg::tok_result_t push0,
    input  stt_pkg::tok_result_t push1,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stt_pkg::tok_result_t out_data
);
    import stt_pkg::*;

    tok_result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wp_reg, wp_next, rp_reg, rp_next;
    logic [FIFO_AW:0]       cnt_reg, cnt_next;
    logic                   pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rp_reg];
    assign room      = cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2);

    // pointer and count update
    always_comb begin
        wp_next  = wp_reg + FIFO_AW'(push_cnt);
        rp_next  = rp_reg + FIFO_AW'(pop);
        cnt_next = cnt_reg + (FIFO_AW+1)'(push_cnt) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) mem_reg[wp_reg] <= push0;
        if (push_cnt == 2'd2) mem_reg[wp_reg + FIFO_AW'(1)] <= push1;
    end

    // checks
    `TOK_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > (FIFO_AW+1)'(FIFO_DEPTH), "count overflow")
    `TOK_NEVER(a_no_overrun, aclk, aresetn, push_cnt != 2'd0 && !room, "push without room")
    `TOK_ASSERT(a_pop_only, aclk, aresetn, (pop && push_cnt == 2'd0) |=> cnt_reg == $past(cnt_reg) - 1'b1, "pop count")
endmodule

// File: design/source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// streaming tokenizer: one source byte per beat in, token beats out
// ----------------------------------------------------------------------------
// the byte that completes a token writes its beat into the result queue
// throughput: one byte per cycle while the result queue has room; a byte that
//   yields two tokens pushes two beats into the four-entry result queue
// input stalls only while the result queue holds more than two beats
// reset: synchronous active-low aresetn clears scanner state and the queue
module source_text_tokenizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [31:0] m_token_start,
    output logic [31:0] m_token_length,
    output logic        m_lex_error,
    output logic        m_last_result
);
    import stt_pkg::*;

    tok_result_t res0, res1, head;
    logic [1:0]  res_cnt, push_cnt;
    logic        room, fire;

    assign s_ready  = room;
    assign fire     = s_valid && s_ready;
    assign push_cnt = fire ? res_cnt : 2'd0;

    // byte scanner
    stt_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (fire),
        .in_byte (s_text_byte),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    // result queue
    stt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (head)
    );

    assign m_token_kind   = head.kind;
    assign m_token_start  = head.start;
    assign m_token_length = head.length;
    assign m_lex_error    = head.err;
    assign m_last_result  = head.last;
endmodule
